// ----- src/mhpq_pkg.sv -----
`timescale 1ns / 1ps

package mhpq_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int LEFT_W   = ADDR_W + 1;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [LEFT_W-1:0] left_t;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [31:0]        pay;
		logic signed [31:0] pri;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load_push;
		logic load_pop;
		logic set_full;
		logic set_empty;
		logic rd_parent;
		logic rd_last;
		logic rd_children;
		logic take_last;
		logic wr_cur;
		logic wr_parent;
		logic wr_child;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic at_root;
		logic no_left;
		logic parent_lt;
		logic child_gt;
	} stat_t;

endpackage

// ----- src/mhpq_datapath.sv -----
`timescale 1ns / 1ps

module mhpq_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mhpq_pkg::cmd_t                cmd,
	input  logic [31:0]                   payload,
	input  logic signed [31:0]            prio,
	output mhpq_pkg::stat_t               stat,
	output mhpq_pkg::entry_t              root,
	output logic [mhpq_pkg::CNT_W-1:0]    count,
	output logic [1:0]                    status
);

	mhpq_pkg::entry_t mem_q [mhpq_pkg::CAPACITY];

	mhpq_pkg::cnt_t   cnt_q;
	mhpq_pkg::addr_t  idx_q;
	logic [1:0]       status_q;
	mhpq_pkg::entry_t cur_q;
	mhpq_pkg::entry_t root_q;
	mhpq_pkg::entry_t rd_a_q;
	mhpq_pkg::entry_t rd_b_q;

	mhpq_pkg::addr_t  idx_dec;
	mhpq_pkg::addr_t  parent_idx;
	mhpq_pkg::left_t  left_idx;
	mhpq_pkg::left_t  right_idx;
	mhpq_pkg::left_t  cnt_ext;
	logic             right_ok;
	mhpq_pkg::entry_t child;
	mhpq_pkg::addr_t  child_idx;
	mhpq_pkg::addr_t  rd_addr_a;
	logic             rd_en;
	logic             wr_en;
	mhpq_pkg::entry_t wr_data;

	assign idx_dec    = idx_q - mhpq_pkg::addr_t'(1);
	assign parent_idx = idx_dec >> 1;
	assign left_idx   = {idx_q, 1'b1};
	assign right_idx  = left_idx + mhpq_pkg::left_t'(1);
	assign cnt_ext    = mhpq_pkg::left_t'(cnt_q);

	// right child wins only when it exists and is strictly larger
	assign right_ok  = (right_idx < cnt_ext) && ($signed(rd_b_q.pri) > $signed(rd_a_q.pri));
	assign child     = right_ok ? rd_b_q : rd_a_q;
	assign child_idx = right_ok ? right_idx[mhpq_pkg::ADDR_W-1:0]
	                            : left_idx[mhpq_pkg::ADDR_W-1:0];

	assign stat.full      = (cnt_q == mhpq_pkg::cnt_t'(mhpq_pkg::CAPACITY));
	assign stat.empty     = (cnt_q == '0);
	assign stat.at_root   = (idx_q == '0);
	assign stat.no_left   = (left_idx >= cnt_ext);
	assign stat.parent_lt = ($signed(cur_q.pri) > $signed(rd_a_q.pri));
	assign stat.child_gt  = ($signed(child.pri) > $signed(cur_q.pri));

	always_comb begin
		if (cmd.rd_last) begin
			rd_addr_a = cnt_q[mhpq_pkg::ADDR_W-1:0];
		end else if (cmd.rd_parent) begin
			rd_addr_a = parent_idx;
		end else begin
			rd_addr_a = left_idx[mhpq_pkg::ADDR_W-1:0];
		end
	end

	assign rd_en = cmd.rd_last | cmd.rd_parent | cmd.rd_children;
	assign wr_en = cmd.wr_cur | cmd.wr_parent | cmd.wr_child;

	always_comb begin
		if (cmd.wr_child) begin
			wr_data = child;
		end else if (cmd.wr_parent) begin
			wr_data = rd_a_q;
		end else begin
			wr_data = cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[idx_q] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem_q[rd_addr_a];
			rd_b_q <= mem_q[right_idx[mhpq_pkg::ADDR_W-1:0]];
		end
	end

	// mirror of entry zero, kept current by every write to the root
	always_ff @(posedge clk) begin
		if (wr_en && (idx_q == '0)) begin
			root_q <= wr_data;
		end
		if (cmd.load_push) begin
			cur_q <= '{pay: payload, pri: prio};
		end else if (cmd.take_last) begin
			cur_q <= rd_a_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			idx_q    <= '0;
			status_q <= mhpq_pkg::ST_OK;
		end else begin
			if (cmd.load_push) begin
				cnt_q    <= cnt_q + mhpq_pkg::cnt_t'(1);
				idx_q    <= cnt_q[mhpq_pkg::ADDR_W-1:0];
				status_q <= mhpq_pkg::ST_OK;
			end else if (cmd.load_pop) begin
				cnt_q    <= cnt_q - mhpq_pkg::cnt_t'(1);
				idx_q    <= '0;
				status_q <= mhpq_pkg::ST_OK;
			end else if (cmd.set_full) begin
				status_q <= mhpq_pkg::ST_FULL;
			end else if (cmd.set_empty) begin
				status_q <= mhpq_pkg::ST_EMPTY;
			end else if (cmd.wr_parent) begin
				idx_q <= parent_idx;
			end else if (cmd.wr_child) begin
				idx_q <= child_idx;
			end
		end
	end

	assign root   = root_q;
	assign count  = cnt_q;
	assign status = status_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mhpq_pkg::cnt_t'(mhpq_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_cur, cmd.wr_parent, cmd.wr_child}))
		else $error("more than one write source selected");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_push |-> !stat.full)
		else $error("push loaded into a full heap");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_pop |-> !stat.empty)
		else $error("pop loaded from an empty heap");
`endif

endmodule

// ----- src/mhpq_ctrl.sv -----
`timescale 1ns / 1ps

module mhpq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            func,
	input  mhpq_pkg::stat_t stat,
	output mhpq_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_PUSH_CHK = 3'd1;
	localparam logic [2:0] S_PUSH_CMP = 3'd2;
	localparam logic [2:0] S_POP_RD   = 3'd3;
	localparam logic [2:0] S_POP_LOAD = 3'd4;
	localparam logic [2:0] S_DOWN_CHK = 3'd5;
	localparam logic [2:0] S_DOWN_CMP = 3'd6;
	localparam logic [2:0] S_RESULT   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_RESULT);
	assign accept = start && !busy;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (func == mhpq_pkg::FUNC_PUSH) begin
						if (stat.full) begin
							cmd.set_full = 1'b1;
							state_d      = S_RESULT;
						end else begin
							cmd.load_push = 1'b1;
							state_d       = S_PUSH_CHK;
						end
					end else begin
						if (stat.empty) begin
							cmd.set_empty = 1'b1;
							state_d       = S_RESULT;
						end else begin
							cmd.load_pop = 1'b1;
							state_d      = S_POP_RD;
						end
					end
				end
			end
			S_PUSH_CHK: begin
				if (stat.at_root) begin
					cmd.wr_cur = 1'b1;
					state_d    = S_RESULT;
				end else begin
					cmd.rd_parent = 1'b1;
					state_d       = S_PUSH_CMP;
				end
			end
			S_PUSH_CMP: begin
				// move the parent down a level, or settle the new entry here
				if (stat.parent_lt) begin
					cmd.wr_parent = 1'b1;
					state_d       = S_PUSH_CHK;
				end else begin
					cmd.wr_cur = 1'b1;
					state_d    = S_RESULT;
				end
			end
			S_POP_RD: begin
				cmd.rd_last = 1'b1;
				state_d     = S_POP_LOAD;
			end
			S_POP_LOAD: begin
				cmd.take_last = 1'b1;
				state_d       = S_DOWN_CHK;
			end
			S_DOWN_CHK: begin
				if (stat.no_left) begin
					cmd.wr_cur = 1'b1;
					state_d    = S_RESULT;
				end else begin
					cmd.rd_children = 1'b1;
					state_d         = S_DOWN_CMP;
				end
			end
			S_DOWN_CMP: begin
				if (stat.child_gt) begin
					cmd.wr_child = 1'b1;
					state_d      = S_DOWN_CHK;
				end else begin
					cmd.wr_cur = 1'b1;
					state_d    = S_RESULT;
				end
			end
			S_RESULT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("transaction accepted but block not busy");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after result strobe");

	a_done_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !accept)
		else $error("transaction accepted during result strobe");

	a_write_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_cur |=> done)
		else $error("final write not followed by result strobe");
`endif

endmodule

// ----- src/max_heap_priority_queue.sv -----
`timescale 1ns / 1ps

// Binary max-heap priority queue, one push or pop per transaction. A transaction
// is taken when start is high and busy is low; busy then stays high until the
// single result has been shown on the result ports for one cycle with done high.
// The receiver cannot stall, so the result must be captured in that cycle. busy
// falls in the cycle after done. Apart from a dropped push or an empty pop, each
// transaction walks the single entry memory: each heap level takes a read
// (parent, or both children on a pop) and then a compare and write, over up to
// log2(capacity) levels on a push and one level fewer on a pop, since a pop leaves
// at most capacity - 1 entries; a pop first fetches the last entry through the
// states S_POP_RD and S_POP_LOAD.
// Entries with equal priority keep the order the heap leaves them in.
module max_heap_priority_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              func,
	input  logic [31:0]                       payload,
	input  logic signed [31:0]                prio,
	output logic                              done,
	output logic                              top_valid,
	output logic [31:0]                       top_payload,
	output logic signed [31:0]                top_prio,
	output logic [mhpq_pkg::CNT_W-1:0]        fill_count,
	output logic [1:0]                        status
);

	mhpq_pkg::cmd_t   cmd;
	mhpq_pkg::stat_t  stat;
	mhpq_pkg::entry_t root;
	mhpq_pkg::cnt_t   count;

	mhpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mhpq_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.payload (payload),
		.prio    (prio),
		.stat    (stat),
		.root    (root),
		.count   (count),
		.status  (status)
	);

	// zero the top fields while the heap is empty
	assign top_valid   = (count != '0);
	assign top_payload = top_valid ? root.pay : '0;
	assign top_prio    = top_valid ? root.pri : '0;
	assign fill_count  = count;

endmodule
